>>> design/q2e_pkg.sv
// Package for the quaternion to Euler angle converter.
// Holds default parameters, angle and root formats and the arctangent table.
// No dependencies.
package q2e_pkg;

  localparam int IN_FRAC_BITS_DEF    = 14;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CORDIC_STAGES_DEF   = 16;

  localparam int ANG_SCALE = 30;
  localparam int ANG_W     = 34;
  localparam int SQ_W      = 62;
  localparam int SQ_CELLS  = 31;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = ANG_W'(64'sd1686629713);

  function automatic logic signed [ANG_W-1:0] atan_q30(input int k);
    logic signed [ANG_W-1:0] r;
    case (k)
      0:  r = ANG_W'(64'sd843314857);
      1:  r = ANG_W'(64'sd497837829);
      2:  r = ANG_W'(64'sd263043837);
      3:  r = ANG_W'(64'sd133525159);
      4:  r = ANG_W'(64'sd67021687);
      5:  r = ANG_W'(64'sd33543516);
      6:  r = ANG_W'(64'sd16775851);
      7:  r = ANG_W'(64'sd8388437);
      8:  r = ANG_W'(64'sd4194283);
      9:  r = ANG_W'(64'sd2097149);
      10: r = ANG_W'(64'sd1048576);
      11: r = ANG_W'(64'sd524288);
      12: r = ANG_W'(64'sd262144);
      13: r = ANG_W'(64'sd131072);
      14: r = ANG_W'(64'sd65536);
      15: r = ANG_W'(64'sd32768);
      16: r = ANG_W'(64'sd16384);
      17: r = ANG_W'(64'sd8192);
      18: r = ANG_W'(64'sd4096);
      19: r = ANG_W'(64'sd2048);
      20: r = ANG_W'(64'sd1024);
      21: r = ANG_W'(64'sd512);
      22: r = ANG_W'(64'sd256);
      23: r = ANG_W'(64'sd128);
      24: r = ANG_W'(64'sd64);
      25: r = ANG_W'(64'sd32);
      26: r = ANG_W'(64'sd16);
      27: r = ANG_W'(64'sd8);
      28: r = ANG_W'(64'sd4);
      29: r = ANG_W'(64'sd2);
      30: r = ANG_W'(64'sd1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/q2e_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
// Depends on q2e_pkg for the root word width.
module q2e_sqrt_cell
  import q2e_pkg::*;
#(
  parameter int BIT_EXP = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [SQ_W-1:0] rem_i,
  input  logic [SQ_W-1:0] root_i,
  output logic [SQ_W-1:0] rem_o,
  output logic [SQ_W-1:0] root_o
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << BIT_EXP;

  logic [SQ_W-1:0] trial;
  logic [SQ_W-1:0] rem_d, root_d, rem_q, root_q;

  assign trial = root_i + BIT;

  always_comb begin
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + BIT;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

>>> design/q2e_cordic_cell.sv
// One rotation cell of the vectoring CORDIC chain.
// Depends on q2e_pkg for the angle format and arctangent table.
module q2e_cordic_cell
  import q2e_pkg::*;
#(
  parameter int W     = 37,
  parameter int SHIFT = 0
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic                    hold_i,
  input  logic signed [W-1:0]     x_i,
  input  logic signed [W-1:0]     y_i,
  input  logic signed [ANG_W-1:0] z_i,
  output logic                    hold_o,
  output logic signed [W-1:0]     x_o,
  output logic signed [W-1:0]     y_o,
  output logic signed [ANG_W-1:0] z_o
);

  localparam logic signed [ANG_W-1:0] ATN = atan_q30(SHIFT);

  logic signed [W-1:0]     x_d, y_d, x_q, y_q, dx, dy;
  logic signed [ANG_W-1:0] z_d, z_q;
  logic                    hold_q;

  assign dx = y_i >>> SHIFT;
  assign dy = x_i >>> SHIFT;

  always_comb begin
    if (hold_i) begin
      x_d = x_i;
      y_d = y_i;
      z_d = z_i;
    end else if (!y_i[W-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATN;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      hold_q <= hold_i;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign hold_o = hold_q;

endmodule

>>> design/quaternion_to_euler.sv
// Quaternion to Z-Y-X Euler angles: products, square root chain, CORDIC chain.
// Pipeline from accepted item to output register: 2 arithmetic stages, a
// squaring stage, 31 root cells, one quadrant stage and one CORDIC cell per
// stage. One item per cycle while in_stall_o is low.
// Reset clears valid bits and the output skid; payload is not reset.
module quaternion_to_euler
  import q2e_pkg::*;
#(
  parameter int IN_FRAC_BITS    = IN_FRAC_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] q_w_i,
  input  logic signed [15:0] q_x_i,
  input  logic signed [15:0] q_y_i,
  input  logic signed [15:0] q_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               pitch_clamped_o
);

  localparam int PW  = ((2*IN_FRAC_BITS > 31) ? 2*IN_FRAC_BITS : 31) + 4;
  localparam int CW  = PW + 2;
  localparam int RSH = (2*IN_FRAC_BITS >= ANG_SCALE) ? 2*IN_FRAC_BITS - ANG_SCALE : 0;
  localparam int LSH = (2*IN_FRAC_BITS < ANG_SCALE) ? ANG_SCALE - 2*IN_FRAC_BITS : 0;
  localparam int DL  = 2 + SQ_CELLS;
  localparam int L   = DL + 2 + CORDIC_STAGES;
  localparam int OSH = ANG_SCALE - ANGLE_FRAC_BITS;
  localparam logic signed [PW-1:0] ONE = PW'(64'sd1 <<< (2*IN_FRAC_BITS));
  localparam logic signed [ANG_W-1:0] RND = ANG_W'(64'sd1 <<< (OSH-1));

  typedef struct packed {
    logic signed [PW-1:0] rx;
    logic signed [PW-1:0] ry;
    logic signed [PW-1:0] yx;
    logic signed [PW-1:0] yy;
    logic signed [31:0]   s30;
  } dl_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } res_t;

  logic en;
  logic v_q [L];
  logic cl_q [L-1];

  assign en = !in_stall_o;

  // products
  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wz_q, p_xy_q, p_zz_q, p_wy_q, p_zx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_wx_q <= q_w_i * q_x_i;
      p_yz_q <= q_y_i * q_z_i;
      p_xx_q <= q_x_i * q_x_i;
      p_yy_q <= q_y_i * q_y_i;
      p_wz_q <= q_w_i * q_z_i;
      p_xy_q <= q_x_i * q_y_i;
      p_zz_q <= q_z_i * q_z_i;
      p_wy_q <= q_w_i * q_y_i;
      p_zx_q <= q_z_i * q_x_i;
    end
  end

  // sums and arcsine argument
  dl_t                dl_d;
  dl_t                dl_q [DL];
  logic signed [PW-1:0] s_raw, s_cl, s_sh;
  logic               cl_d;

  always_comb begin
    dl_d.ry = (PW'(p_wx_q) + PW'(p_yz_q)) <<< 1;
    dl_d.rx = ONE - ((PW'(p_xx_q) + PW'(p_yy_q)) <<< 1);
    dl_d.yy = (PW'(p_wz_q) + PW'(p_xy_q)) <<< 1;
    dl_d.yx = ONE - ((PW'(p_yy_q) + PW'(p_zz_q)) <<< 1);
    s_raw   = (PW'(p_wy_q) - PW'(p_zx_q)) <<< 1;
    if (s_raw > ONE) begin
      s_cl = ONE;
      cl_d = 1'b1;
    end else if (s_raw < -ONE) begin
      s_cl = -ONE;
      cl_d = 1'b1;
    end else begin
      s_cl = s_raw;
      cl_d = 1'b0;
    end
    s_sh     = (s_cl >>> RSH) <<< LSH;
    dl_d.s30 = s_sh[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0] <= dl_d;
      for (int k = 1; k < DL; k++) dl_q[k] <= dl_q[k-1];
    end
  end

  // square and root chain
  logic signed [63:0] sq_full;
  logic [SQ_W-1:0]    sq_q;
  logic [SQ_W-1:0]    sr_rem  [SQ_CELLS+1];
  logic [SQ_W-1:0]    sr_root [SQ_CELLS+1];

  assign sq_full = dl_q[0].s30 * dl_q[0].s30;

  always_ff @(posedge clk_i) begin
    if (en) sq_q <= sq_full[SQ_W-1:0];
  end

  assign sr_rem[0]  = (SQ_W'(1) << (2*ANG_SCALE)) - sq_q;
  assign sr_root[0] = '0;

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    q2e_sqrt_cell #(
      .BIT_EXP(2*(SQ_CELLS-1-k))
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (sr_rem[k]),
      .root_i (sr_root[k]),
      .rem_o  (sr_rem[k+1]),
      .root_o (sr_root[k+1])
    );
  end

  // quadrant stage
  logic signed [CW-1:0]    lx [3];
  logic signed [CW-1:0]    ly [3];
  logic signed [CW-1:0]    cx [CORDIC_STAGES+1][3];
  logic signed [CW-1:0]    cy [CORDIC_STAGES+1][3];
  logic signed [ANG_W-1:0] cz [CORDIC_STAGES+1][3];
  logic                    ch [CORDIC_STAGES+1][3];

  assign lx[0] = CW'(dl_q[DL-1].rx);
  assign ly[0] = CW'(dl_q[DL-1].ry);
  assign lx[1] = CW'($signed({1'b0, sr_root[SQ_CELLS][30:0]}));
  assign ly[1] = CW'(dl_q[DL-1].s30);
  assign lx[2] = CW'(dl_q[DL-1].yx);
  assign ly[2] = CW'(dl_q[DL-1].yy);

  for (genvar j = 0; j < 3; j++) begin : g_quad
    logic signed [CW-1:0]    x_d, y_d;
    logic signed [ANG_W-1:0] z_d;
    logic                    h_d;
    logic signed [CW-1:0]    x_q, y_q;
    logic signed [ANG_W-1:0] z_q;
    logic                    h_q;

    always_comb begin
      x_d = lx[j];
      y_d = ly[j];
      z_d = '0;
      h_d = 1'b0;
      if (lx[j] == '0) begin
        h_d = 1'b1;
        if (ly[j] > 0)      z_d = HALF_PI_Q30;
        else if (ly[j] < 0) z_d = -HALF_PI_Q30;
      end else if (lx[j] < 0) begin
        if (!ly[j][CW-1]) begin
          x_d = ly[j];
          y_d = -lx[j];
          z_d = HALF_PI_Q30;
        end else begin
          x_d = -ly[j];
          y_d = lx[j];
          z_d = -HALF_PI_Q30;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        x_q <= x_d;
        y_q <= y_d;
        z_q <= z_d;
        h_q <= h_d;
      end
    end

    assign cx[0][j] = x_q;
    assign cy[0][j] = y_q;
    assign cz[0][j] = z_q;
    assign ch[0][j] = h_q;
  end

  // rotation chain
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    for (genvar j = 0; j < 3; j++) begin : g_lane
      q2e_cordic_cell #(
        .W     (CW),
        .SHIFT (i)
      ) u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .hold_i (ch[i][j]),
        .x_i    (cx[i][j]),
        .y_i    (cy[i][j]),
        .z_i    (cz[i][j]),
        .hold_o (ch[i+1][j]),
        .x_o    (cx[i+1][j]),
        .y_o    (cy[i+1][j]),
        .z_o    (cz[i+1][j])
      );
    end
  end

  // valid and clamp flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < L; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int k = 1; k < L; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cl_q[0] <= cl_d;
      for (int k = 1; k < L-1; k++) cl_q[k] <= cl_q[k-1];
    end
  end

  // round, saturate and hand to the output skid
  function automatic logic signed [15:0] to_out(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] r;
    r = (a + RND) >>> OSH;
    if (r > ANG_W'(32767))       return 16'sh7fff;
    else if (r < -ANG_W'(32768)) return 16'sh8000;
    else                         return r[15:0];
  endfunction

  res_t p_d, out_q, skid_dq;
  logic out_v_q, out_v_d, skid_q, skid_d, ld_out, ld_skid, ld_back;

  always_comb begin
    p_d.roll    = to_out(cz[CORDIC_STAGES][0]);
    p_d.pitch   = to_out(cz[CORDIC_STAGES][1]);
    p_d.yaw     = to_out(cz[CORDIC_STAGES][2]);
    p_d.clamped = cl_q[L-2];
  end

  assign ld_back = skid_q && !out_stall_i;
  assign ld_out  = !skid_q && v_q[L-1] && (!out_v_q || !out_stall_i);
  assign ld_skid = !skid_q && v_q[L-1] && out_v_q && out_stall_i;
  assign out_v_d = ld_back || ld_out || (out_v_q && out_stall_i);
  assign skid_d  = ld_skid || (skid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skid_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      skid_q  <= skid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_back)     out_q   <= skid_dq;
    else if (ld_out) out_q   <= p_d;
    if (ld_skid)     skid_dq <= p_d;
  end

  assign in_stall_o      = skid_q;
  assign out_valid_o     = out_v_q;
  assign roll_angle_o    = out_q.roll;
  assign pitch_angle_o   = out_q.pitch;
  assign yaw_angle_o     = out_q.yaw;
  assign pitch_clamped_o = out_q.clamped;

endmodule

>>> design/q2e_checker.sv
// Port-level checks for quaternion_to_euler, with the bind that attaches them.
// Depends on the top level's port list only.
module q2e_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic signed [15:0] q_w_i,
  input logic signed [15:0] q_x_i,
  input logic signed [15:0] q_y_i,
  input logic signed [15:0] q_z_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] roll_angle_o,
  input logic signed [15:0] pitch_angle_o,
  input logic signed [15:0] yaw_angle_o,
  input logic               pitch_clamped_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(roll_angle_o) && $stable(pitch_angle_o)
      && $stable(yaw_angle_o) && $stable(pitch_clamped_o))
    else $error("stalled output item changed");

  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && out_stall_i |=> in_stall_o)
    else $error("skid released while output stalled");

  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> $past(!out_stall_i))
    else $error("skid released without output taken");

endmodule

bind quaternion_to_euler q2e_checker u_q2e_checker (.*);
